// ----- src/ise_pkg.sv -----
// Shared widths, request codes and arithmetic unit flags for the interpolation search engine.
package ise_pkg;

  // Field widths of the request, response and configuration items
  localparam int KEY_W   = 64;
  localparam int IDX_W   = 10;
  localparam int COUNT_W = 11;

  // Default number of table entries
  localparam int TABLE_DEPTH_DEFAULT = 1024;

  // Request type codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // Status flags of the shared add/subtract unit
  typedef struct packed {
    logic no_borrow;  // a >= b on a subtract
    logic zero;       // result is all zeros
  } alu_flags_t;

endpackage

// ----- src/ise_if.sv -----
// Handshake channels of the interpolation search engine: request, response and configuration.
interface ise_req_if import ise_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [IDX_W-1:0] entry_index;
  logic [KEY_W-1:0] entry_value;
  logic [KEY_W-1:0] search_key;

  modport source (output valid, req_type, entry_index, entry_value, search_key, input ready);
  modport sink   (input valid, req_type, entry_index, entry_value, search_key, output ready);
endinterface

interface ise_rsp_if import ise_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

interface ise_cfg_if import ise_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink   (input valid, entry_count, output ready);
endinterface

// ----- src/ise_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ise_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/ise_alu.sv -----
// Shared add/subtract unit used for every key compare, multiply step and divide step.
module ise_alu import ise_pkg::*; #(
  parameter int W = 74
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] sum_o,
  output alu_flags_t   flags_o
);

  logic [W:0] wide;

  // One carry chain: a + b, or a + ~b + 1 for a subtract
  assign wide = {1'b0, a_i} + {1'b0, (sub_i ? ~b_i : b_i)} + (W+1)'(sub_i);
  assign sum_o = wide[W-1:0];
  assign flags_o.no_borrow = wide[W];
  assign flags_o.zero = (wide[W-1:0] == '0);

endmodule

// ----- src/interpolation_search_engine.sv -----
// Top level of the interpolation search engine: table RAM, shared arithmetic unit and sequencer.
//
//  channel   dir   handshake            payload
//  cfg_i     in    valid/ready          entry_count (11 b)
//  req_i     in    valid/ready          req_type, entry_index, entry_value, search_key
//  rsp_o     out   valid/ready          found, position (one item per search)
//
// A load item writes the table at the edge that accepts it.
// A search item reads both window ends and runs a multiply and a divide for each probe;
// AW = clog2(TABLE_DEPTH); a 64+AW bit adder does one multiply or divide bit per cycle.
// Reset clears the sequencer, the search window, the result valid flag and sets entry_count
// to 1; the table holds garbage until written and needs no clearing pass.
// Requests are taken only while the sequencer is idle; a pending result waits in its
// register without blocking loads, and a finished search holds until that register frees.
module interpolation_search_engine import ise_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ise_cfg_if.sink   cfg_i,
  ise_req_if.sink   req_i,
  ise_rsp_if.source rsp_o
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int UW  = KEY_W + AW;
  localparam int STW = $clog2(AW + 1);

  // Sequencer state codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RLO  = 4'd1;
  localparam logic [3:0] ST_RHI  = 4'd2;
  localparam logic [3:0] ST_SUB1 = 4'd3;
  localparam logic [3:0] ST_SUB2 = 4'd4;
  localparam logic [3:0] ST_SUB3 = 4'd5;
  localparam logic [3:0] ST_MUL  = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_MID  = 4'd8;
  localparam logic [3:0] ST_MCMP = 4'd9;
  localparam logic [3:0] ST_CHK  = 4'd10;
  localparam logic [3:0] ST_DONE = 4'd11;

  logic [3:0]         state_q, state_d;
  logic [COUNT_W-1:0] entry_count_q, entry_count_d;
  logic [AW-1:0]      low_q, low_d, high_q, high_d;
  logic               out_valid_q, out_valid_d;
  logic               out_found_q, out_found_d;
  logic [IDX_W-1:0]   out_pos_q, out_pos_d;

  logic [KEY_W-1:0]   key_q, key_d, vlo_q, vlo_d, vhi_q, vhi_d;
  logic [KEY_W-1:0]   dif_q, dif_d, span_v_q, span_v_d;
  logic [UW-1:0]      prod_q, prod_d;
  logic [AW-1:0]      span_i_q, span_i_d, mid_q, mid_d, pos_q, pos_d;
  logic [STW-1:0]     step_q, step_d;
  logic               hit_q, hit_d;

  logic               req_acc, rsp_free;
  logic               load_we;
  logic [AW+IDX_W-1:0] idx_ext;
  logic [AW+COUNT_W:0] cnt_ext;
  logic [AW-1:0]      high_init;
  logic [AW-1:0]      raddr;
  logic [KEY_W-1:0]   rdata;
  logic [KEY_W:0]     rem;
  logic [AW:0]        quot_shift;
  logic [AW+IDX_W-1:0] pos_ext;

  logic [UW-1:0]      alu_a, alu_b, alu_sum;
  logic               alu_sub;
  alu_flags_t         alu_flags;

  // Handshakes
  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign rsp_free    = !out_valid_q || rsp_o.ready;

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.found    = out_found_q;
  assign rsp_o.position = out_pos_q;

  // Load address range check
  assign idx_ext = {{AW{1'b0}}, req_i.entry_index};
  assign load_we = req_acc && (req_i.req_type == REQ_LOAD) &&
                   (idx_ext < (AW+IDX_W)'(TABLE_DEPTH));

  // Upper end of the initial window from the active entry count
  assign cnt_ext = {{(AW+1){1'b0}}, entry_count_q};
  always_comb begin
    if (cnt_ext == '0) begin
      high_init = '0;
    end else if (cnt_ext > (AW+COUNT_W+1)'(TABLE_DEPTH)) begin
      high_init = AW'(TABLE_DEPTH - 1);
    end else begin
      high_init = cnt_ext[AW-1:0] - AW'(1);
    end
  end

  // Divide step operands: remainder shifted with the next dividend bit
  assign rem        = {prod_q[UW-1:AW], prod_q[AW-1]};
  assign quot_shift = {prod_q[AW-1:0], alu_flags.no_borrow};

  // Probe position; the quotient never exceeds the window span
  assign mid_d = low_q + prod_q[AW-1:0];

  ise_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (idx_ext[AW-1:0]),
    .wdata_i (req_i.entry_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ise_alu #(
    .W (UW)
  ) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .sum_o   (alu_sum),
    .flags_o (alu_flags)
  );

  // Select table read address
  always_comb begin
    case (state_q)
      ST_RHI:  raddr = high_q;
      ST_MID:  raddr = mid_d;
      default: raddr = low_q;
    endcase
  end

  // Route operands to the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (state_q)
      ST_SUB1, ST_CHK: begin
        alu_a = UW'(key_q);
        alu_b = UW'(vlo_q);
      end
      ST_SUB2: begin
        alu_a = UW'(vhi_q);
        alu_b = UW'(key_q);
      end
      ST_SUB3: begin
        alu_a = UW'(vhi_q);
        alu_b = UW'(vlo_q);
      end
      ST_MUL: begin
        alu_a   = {prod_q[UW-2:0], 1'b0};
        alu_b   = span_i_q[AW-1] ? UW'(dif_q) : '0;
        alu_sub = 1'b0;
      end
      ST_DIV: begin
        alu_a = UW'(rem);
        alu_b = UW'(span_v_q);
      end
      ST_MCMP: begin
        alu_a = UW'(key_q);
        alu_b = UW'(rdata);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  // Sequencer and datapath next values
  always_comb begin
    state_d       = state_q;
    entry_count_d = entry_count_q;
    low_d         = low_q;
    high_d        = high_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    out_found_d   = out_found_q;
    out_pos_d     = out_pos_q;
    key_d         = key_q;
    vlo_d         = vlo_q;
    vhi_d         = vhi_q;
    dif_d         = dif_q;
    span_v_d      = span_v_q;
    prod_d        = prod_q;
    span_i_d      = span_i_q;
    step_d        = step_q;
    hit_d         = hit_q;
    pos_d         = pos_q;

    if (cfg_i.valid && cfg_i.ready) begin
      entry_count_d = cfg_i.entry_count;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_acc && (req_i.req_type == REQ_SEARCH)) begin
          key_d   = req_i.search_key;
          low_d   = '0;
          high_d  = high_init;
          hit_d   = 1'b0;
          pos_d   = '0;
          state_d = ST_RLO;
        end
      end
      ST_RLO: begin
        state_d = ST_RHI;
      end
      ST_RHI: begin
        vlo_d   = rdata;
        state_d = ST_SUB1;
      end
      // key below the low end: stop probing
      ST_SUB1: begin
        vhi_d = rdata;
        dif_d = alu_sum[KEY_W-1:0];
        state_d = alu_flags.no_borrow ? ST_SUB2 : ST_CHK;
      end
      // key above the high end: stop probing
      ST_SUB2: begin
        state_d = alu_flags.no_borrow ? ST_SUB3 : ST_CHK;
      end
      // equal end values: stop probing, else start the multiply
      ST_SUB3: begin
        span_v_d = alu_sum[KEY_W-1:0];
        span_i_d = high_q - low_q;
        prod_d   = '0;
        step_d   = STW'(AW - 1);
        state_d  = alu_flags.zero ? ST_CHK : ST_MUL;
      end
      // Shift-add one bit of the index span per cycle, MSB first
      ST_MUL: begin
        prod_d   = alu_sum;
        span_i_d = span_i_q << 1;
        if (step_q == '0) begin
          step_d  = STW'(AW - 1);
          state_d = ST_DIV;
        end else begin
          step_d = step_q - STW'(1);
        end
      end
      // Restoring divide: one quotient bit per cycle into the low end of the product
      ST_DIV: begin
        prod_d = {(alu_flags.no_borrow ? alu_sum[KEY_W-1:0] : rem[KEY_W-1:0]),
                  quot_shift[AW-1:0]};
        if (step_q == '0) begin
          state_d = ST_MID;
        end else begin
          step_d = step_q - STW'(1);
        end
      end
      ST_MID: begin
        state_d = ST_MCMP;
      end
      // Narrow the window or stop on a hit
      ST_MCMP: begin
        if (alu_flags.zero) begin
          hit_d   = 1'b1;
          pos_d   = mid_q;
          state_d = ST_DONE;
        end else if (alu_flags.no_borrow) begin
          low_d   = mid_q + AW'(1);
          state_d = ST_RLO;
        end else begin
          high_d  = mid_q - AW'(1);
          state_d = ST_RLO;
        end
      end
      // Final check of the low end
      ST_CHK: begin
        if (alu_flags.zero) begin
          hit_d = 1'b1;
          pos_d = low_q;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_free) begin
          out_valid_d = 1'b1;
          out_found_d = hit_q;
          out_pos_d   = hit_q ? pos_ext[IDX_W-1:0] : '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign pos_ext = {{IDX_W{1'b0}}, pos_q};

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      entry_count_q <= COUNT_W'(1);
      low_q         <= '0;
      high_q        <= '0;
      out_valid_q   <= 1'b0;
      step_q        <= '0;
    end else begin
      state_q       <= state_d;
      entry_count_q <= entry_count_d;
      low_q         <= low_d;
      high_q        <= high_d;
      out_valid_q   <= out_valid_d;
      step_q        <= step_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_found_q <= out_found_d;
    out_pos_q   <= out_pos_d;
    key_q       <= key_d;
    vlo_q       <= vlo_d;
    vhi_q       <= vhi_d;
    dif_q       <= dif_d;
    span_v_q    <= span_v_d;
    prod_q      <= prod_d;
    span_i_q    <= span_i_d;
    mid_q       <= (state_q == ST_MID) ? mid_d : mid_q;
    hit_q       <= hit_d;
    pos_q       <= pos_d;
  end

  // Search window never inverts while a search runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (low_q <= high_q))
    else $error("search window inverted");

  // An accepted search starts with a read of the low end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && (req_i.req_type == REQ_SEARCH)) |=> (state_q == ST_RLO))
    else $error("search not started");

  // A result appears only from the finish state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result outside finish state");

  // Bit counter stays within the index width during multiply and divide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_MUL) || (state_q == ST_DIV)) |-> (step_q <= STW'(AW - 1)))
    else $error("step counter out of range");

endmodule
